// ----- rtl/gjr_pkg.sv -----
// Shared constants, state type and helper functions for the Gauss-Jordan reducer.
`timescale 1ns / 1ps
`default_nettype none
package gjr_pkg;

  localparam int MAX_ROWS  = 8;
  localparam int MAX_COLS  = 8;
  localparam int ROW_W     = 3;
  localparam int COL_W     = 3;
  localparam int CNT_W     = 4;
  localparam int ADDR_W    = ROW_W + COL_W;
  localparam int DEPTH     = MAX_ROWS * MAX_COLS;
  localparam int TOL_W     = 63;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 63;

  localparam logic [CFG_IDX_W-1:0] REG_TOL  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROWS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COLS = 2'd2;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_COL,
    ST_SRD,
    ST_SMUL,
    ST_SCMP,
    ST_DEC,
    ST_PRD,
    ST_PLAT,
    ST_DRD,
    ST_DGO,
    ST_DWAIT,
    ST_ERD,
    ST_EF,
    ST_EA,
    ST_EM,
    ST_ET,
    ST_EW,
    ST_ORD,
    ST_OLD,
    ST_OWAIT
  } gjr_state_t;

  // clamp an active size register to 1..maxv
  function automatic logic [CNT_W-1:0] act_cnt(input logic [CNT_W-1:0] v,
                                               input logic [CNT_W-1:0] maxv);
    logic [CNT_W-1:0] res;
    if (v == '0) res = CNT_W'(1);
    else if (v > maxv) res = maxv;
    else res = v;
    return res;
  endfunction

  function automatic logic [31:0] sat32(input logic signed [63:0] v);
    logic [31:0] res;
    if (v > 64'sd2147483647) res = 32'h7FFF_FFFF;
    else if (v < -64'sd2147483648) res = 32'h8000_0000;
    else res = v[31:0];
    return res;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/gauss_jordan_rref.sv -----
// Top level: matrix store, elimination sequencer with shared multiplier, output stage.
// Usage: load matrix entries on the in_ channel, one item per cycle, each with
// its row, column and Q16.16 value. The item with in_load_last set starts the
// reduction; in_ready stays low until every result item has been taken.
// Results leave on the out_ channel row-major over the active area, each
// with the pivot-column flag and the rank; out_last marks the final one.
// cfg_ writes set the tolerance and the active size; cfg_ready is always high.
// After the last load, each column runs a pivot search on the shared 32x32
// multiplier; each pivot adds division in the bit-serial divider (48 quotient
// bits) and multiply-subtract through the single store read port. Each result
// item is read from the store and loaded into the output registers, and the
// next is not read until it is taken; out_valid holds with stable payload
// while out_ready is low.
// Reset (rst_n low, synchronous) clears the store, pivot state and registers
// to tolerance 0 and an 8x8 active area. The store is cleared at once after
// the last result is taken.
`timescale 1ns / 1ps
`default_nettype none
module gauss_jordan_rref import gjr_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic [ROW_W-1:0]     in_row_index,
  input  wire logic [COL_W-1:0]     in_col_index,
  input  wire logic signed [31:0]   in_entry_value,
  input  wire logic                 in_load_last,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic [ROW_W-1:0]          out_row,
  output logic [COL_W-1:0]          out_col,
  output logic signed [31:0]        out_value,
  output logic                      out_is_pivot_column,
  output logic [CNT_W-1:0]          out_matrix_rank,
  output logic                      out_last,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_DAT_W-1:0] cfg_data
);

  gjr_state_t state_r, state_nxt;

  logic [TOL_W-1:0] tol_r;
  logic [CNT_W-1:0] rows_r, cols_r;

  logic [ROW_W-1:0] perm_r [MAX_ROWS];
  logic [ROW_W-1:0] perm_nxt [MAX_ROWS];
  logic [DEPTH-1:0] valid_r, valid_nxt;

  logic [CNT_W-1:0] i_r, i_nxt, j_r, j_nxt, r_r, r_nxt, c_r, c_nxt;
  logic [ROW_W-1:0] k_r, k_nxt;
  logic [63:0]      best_r, best_nxt;
  logic [31:0]      piv_r, piv_nxt, f_r, f_nxt, tq_r, tq_nxt;
  logic signed [63:0] prod_r, prod_nxt;
  logic [MAX_COLS-1:0] pmask_r, pmask_nxt;
  logic [CNT_W-1:0] rank_r, rank_nxt;

  logic                out_valid_r, out_valid_nxt;
  logic [ROW_W-1:0]    orow_r, orow_nxt;
  logic [COL_W-1:0]    ocol_r, ocol_nxt;
  logic [31:0]         oval_r, oval_nxt;
  logic                opiv_r, opiv_nxt;
  logic                olast_r, olast_nxt;

  logic [31:0]       mem [DEPTH];
  logic [31:0]       rd_q_r;
  logic              rd_en, wr_en;
  logic [ADDR_W-1:0] addr;
  logic [31:0]       wr_data;

  logic [CNT_W-1:0]  nr, nc;
  logic [ROW_W-1:0]  pr_i, pr_r;
  logic signed [31:0] mul_a, mul_b;
  logic signed [63:0] adj;
  logic signed [63:0] diff;
  logic               div_start, div_done;
  logic [31:0]        div_q;
  logic               row_more, col_more;

  gjr_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (rd_q_r),
    .den   (piv_r),
    .done  (div_done),
    .quot  (div_q)
  );

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r  <= '0;
      rows_r <= CNT_W'(MAX_ROWS);
      cols_r <= CNT_W'(MAX_COLS);
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_TOL:  tol_r  <= cfg_data[TOL_W-1:0];
        REG_ROWS: rows_r <= cfg_data[CNT_W-1:0];
        REG_COLS: cols_r <= cfg_data[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[addr] <= wr_data;
    if (rd_en) rd_q_r <= valid_r[addr] ? mem[addr] : 32'h0;
  end

  always_comb begin
    nr   = act_cnt(rows_r, CNT_W'(MAX_ROWS));
    nc   = act_cnt(cols_r, CNT_W'(MAX_COLS));
    pr_i = perm_r[i_r[ROW_W-1:0]];
    pr_r = perm_r[r_r[ROW_W-1:0]];
    row_more = (r_r + CNT_W'(1)) < nr;
    col_more = (c_r + CNT_W'(1)) < nc;
    adj  = prod_r + (prod_r[63] ? 64'sd65535 : 64'sd0);
    diff = 64'(signed'(rd_q_r)) - 64'(signed'(tq_r));
  end

  always_comb begin
    state_nxt = state_r;
    for (int n = 0; n < MAX_ROWS; n++) perm_nxt[n] = perm_r[n];
    valid_nxt = valid_r;
    i_nxt = i_r; j_nxt = j_r; r_nxt = r_r; c_nxt = c_r; k_nxt = k_r;
    best_nxt = best_r; piv_nxt = piv_r; f_nxt = f_r; tq_nxt = tq_r;
    pmask_nxt = pmask_r; rank_nxt = rank_r;
    out_valid_nxt = out_valid_r;
    orow_nxt = orow_r; ocol_nxt = ocol_r; oval_nxt = oval_r;
    opiv_nxt = opiv_r; olast_nxt = olast_r;
    rd_en = 1'b0; wr_en = 1'b0; addr = '0; wr_data = '0;
    div_start = 1'b0;
    in_ready = 1'b0;
    mul_a = signed'(rd_q_r);
    mul_b = signed'(rd_q_r);
    if (state_r == ST_EM) mul_a = signed'(f_r);
    prod_nxt = mul_a * mul_b;

    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          wr_en   = 1'b1;
          addr    = {in_row_index, in_col_index};
          wr_data = in_entry_value;
          valid_nxt[{in_row_index, in_col_index}] = 1'b1;
          if (in_load_last) begin
            i_nxt = '0; j_nxt = '0; pmask_nxt = '0; rank_nxt = '0;
            state_nxt = ST_COL;
          end
        end
      end
      ST_COL: begin
        if (i_r >= nr || j_r >= nc) begin
          r_nxt = '0; c_nxt = '0;
          state_nxt = ST_ORD;
        end else begin
          r_nxt = i_r; best_nxt = '0; k_nxt = i_r[ROW_W-1:0];
          state_nxt = ST_SRD;
        end
      end
      ST_SRD: begin
        rd_en = 1'b1;
        addr  = {pr_r, j_r[COL_W-1:0]};
        state_nxt = ST_SMUL;
      end
      ST_SMUL: state_nxt = ST_SCMP;
      ST_SCMP: begin
        if (unsigned'(prod_r) > best_r) begin
          best_nxt = unsigned'(prod_r);
          k_nxt = r_r[ROW_W-1:0];
        end
        if (row_more) begin
          r_nxt = r_r + CNT_W'(1);
          state_nxt = ST_SRD;
        end else begin
          state_nxt = ST_DEC;
        end
      end
      ST_DEC: begin
        if (best_r <= {1'b0, tol_r}) begin
          j_nxt = j_r + CNT_W'(1);
          state_nxt = ST_COL;
        end else begin
          pmask_nxt[j_r[COL_W-1:0]] = 1'b1;
          rank_nxt = rank_r + CNT_W'(1);
          perm_nxt[i_r[ROW_W-1:0]] = perm_r[k_r];
          perm_nxt[k_r] = perm_r[i_r[ROW_W-1:0]];
          state_nxt = ST_PRD;
        end
      end
      ST_PRD: begin
        rd_en = 1'b1;
        addr  = {pr_i, j_r[COL_W-1:0]};
        state_nxt = ST_PLAT;
      end
      ST_PLAT: begin
        piv_nxt = rd_q_r;
        c_nxt = '0;
        state_nxt = ST_DRD;
      end
      ST_DRD: begin
        rd_en = 1'b1;
        addr  = {pr_i, c_r[COL_W-1:0]};
        state_nxt = ST_DGO;
      end
      ST_DGO: begin
        div_start = 1'b1;
        state_nxt = ST_DWAIT;
      end
      ST_DWAIT: begin
        if (div_done) begin
          wr_en   = 1'b1;
          addr    = {pr_i, c_r[COL_W-1:0]};
          wr_data = div_q;
          valid_nxt[{pr_i, c_r[COL_W-1:0]}] = 1'b1;
          if (col_more) begin
            c_nxt = c_r + CNT_W'(1);
            state_nxt = ST_DRD;
          end else begin
            r_nxt = '0;
            state_nxt = ST_ERD;
          end
        end
      end
      ST_ERD: begin
        if (r_r == i_r) begin
          if (row_more) begin
            r_nxt = r_r + CNT_W'(1);
          end else begin
            i_nxt = i_r + CNT_W'(1);
            j_nxt = j_r + CNT_W'(1);
            state_nxt = ST_COL;
          end
        end else begin
          rd_en = 1'b1;
          addr  = {pr_r, j_r[COL_W-1:0]};
          state_nxt = ST_EF;
        end
      end
      ST_EF: begin
        f_nxt = rd_q_r;
        c_nxt = '0;
        state_nxt = ST_EA;
      end
      ST_EA: begin
        rd_en = 1'b1;
        addr  = {pr_i, c_r[COL_W-1:0]};
        state_nxt = ST_EM;
      end
      ST_EM: begin
        // product uses the pivot-row entry while the target entry is fetched
        rd_en = 1'b1;
        addr  = {pr_r, c_r[COL_W-1:0]};
        state_nxt = ST_ET;
      end
      ST_ET: begin
        tq_nxt = sat32(adj >>> 16);
        state_nxt = ST_EW;
      end
      ST_EW: begin
        wr_en   = 1'b1;
        addr    = {pr_r, c_r[COL_W-1:0]};
        wr_data = sat32(diff);
        valid_nxt[{pr_r, c_r[COL_W-1:0]}] = 1'b1;
        if (col_more) begin
          c_nxt = c_r + CNT_W'(1);
          state_nxt = ST_EA;
        end else if (row_more) begin
          r_nxt = r_r + CNT_W'(1);
          state_nxt = ST_ERD;
        end else begin
          i_nxt = i_r + CNT_W'(1);
          j_nxt = j_r + CNT_W'(1);
          state_nxt = ST_COL;
        end
      end
      ST_ORD: begin
        rd_en = 1'b1;
        addr  = {pr_r, c_r[COL_W-1:0]};
        state_nxt = ST_OLD;
      end
      ST_OLD: begin
        out_valid_nxt = 1'b1;
        orow_nxt  = r_r[ROW_W-1:0];
        ocol_nxt  = c_r[COL_W-1:0];
        oval_nxt  = rd_q_r;
        opiv_nxt  = pmask_r[c_r[COL_W-1:0]];
        olast_nxt = !row_more && !col_more;
        state_nxt = ST_OWAIT;
      end
      ST_OWAIT: begin
        if (out_ready) begin
          out_valid_nxt = 1'b0;
          if (olast_r) begin
            valid_nxt = '0;
            for (int n = 0; n < MAX_ROWS; n++) perm_nxt[n] = ROW_W'(n);
            state_nxt = ST_IDLE;
          end else begin
            if (col_more) begin
              c_nxt = c_r + CNT_W'(1);
            end else begin
              c_nxt = '0;
              r_nxt = r_r + CNT_W'(1);
            end
            state_nxt = ST_ORD;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      valid_r     <= '0;
      out_valid_r <= 1'b0;
      pmask_r     <= '0;
      rank_r      <= '0;
      for (int n = 0; n < MAX_ROWS; n++) perm_r[n] <= ROW_W'(n);
    end else begin
      state_r     <= state_nxt;
      valid_r     <= valid_nxt;
      out_valid_r <= out_valid_nxt;
      pmask_r     <= pmask_nxt;
      rank_r      <= rank_nxt;
      for (int n = 0; n < MAX_ROWS; n++) perm_r[n] <= perm_nxt[n];
    end
    i_r <= i_nxt; j_r <= j_nxt; r_r <= r_nxt; c_r <= c_nxt; k_r <= k_nxt;
    best_r <= best_nxt; piv_r <= piv_nxt; f_r <= f_nxt; tq_r <= tq_nxt;
    prod_r <= prod_nxt;
    orow_r <= orow_nxt; ocol_r <= ocol_nxt; oval_r <= oval_nxt;
    opiv_r <= opiv_nxt; olast_r <= olast_nxt;
  end

  assign out_valid           = out_valid_r;
  assign out_row             = orow_r;
  assign out_col             = ocol_r;
  assign out_value           = oval_r;
  assign out_is_pivot_column = opiv_r;
  assign out_matrix_rank     = rank_r;
  assign out_last            = olast_r;

endmodule
`default_nettype wire

// ----- rtl/gjr_div.sv -----
// Bit-serial signed divider: (num * 65536) / den, truncated, saturated to 32 bits.
`timescale 1ns / 1ps
`default_nettype none
module gjr_div import gjr_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [31:0] num,
  input  wire logic [31:0] den,
  output logic             done,
  output logic [31:0]      quot
);

  localparam int QW = 48;

  logic          busy_r, busy_nxt;
  logic          fin_r, fin_nxt;
  logic [5:0]    cnt_r, cnt_nxt;
  logic [QW-1:0] quo_r, quo_nxt;
  logic [31:0]   rem_r, rem_nxt;
  logic [31:0]   dmag_r, dmag_nxt;
  logic          neg_r, neg_nxt;

  logic signed [QW-1:0] a_s;
  logic [32:0]          trial;
  logic                 ge;
  logic signed [48:0]   q_s;

  always_comb begin
    a_s   = signed'({num, 16'h0000});
    trial = {rem_r, quo_r[QW-1]};
    ge    = trial >= {1'b0, dmag_r};
    busy_nxt = busy_r;
    fin_nxt  = 1'b0;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dmag_nxt = dmag_r;
    neg_nxt  = neg_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      quo_nxt  = a_s[QW-1] ? QW'(-a_s) : QW'(a_s);
      rem_nxt  = '0;
      dmag_nxt = den[31] ? 32'(-signed'(den)) : den;
      neg_nxt  = num[31] ^ den[31];
    end else if (busy_r) begin
      rem_nxt = ge ? 32'(trial - {1'b0, dmag_r}) : trial[31:0];
      quo_nxt = {quo_r[QW-2:0], ge};
      cnt_nxt = cnt_r + 6'd1;
      if (cnt_r == 6'(QW - 1)) begin
        busy_nxt = 1'b0;
        fin_nxt  = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      fin_r  <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      fin_r  <= fin_nxt;
    end
    cnt_r  <= cnt_nxt;
    quo_r  <= quo_nxt;
    rem_r  <= rem_nxt;
    dmag_r <= dmag_nxt;
    neg_r  <= neg_nxt;
  end

  always_comb begin
    q_s  = neg_r ? -signed'({1'b0, quo_r}) : signed'({1'b0, quo_r});
    quot = sat32(64'(q_s));
    done = fin_r;
  end

endmodule
`default_nettype wire
